>>> rtl/twpd_pkg.sv
package twpd_pkg;

  // PWM period in counter steps; duties saturate here
  localparam logic [3:0] PWM_STEPS = 4'd10;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENT_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_THR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_TICKS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_SPEED   = 2'd3;

  // Configuration reset values
  localparam logic [9:0] PRESENT_THR_RST = 10'd560;
  localparam logic [9:0] CLEAR_THR_RST   = 10'd434;
  localparam logic [7:0] RAMP_TICKS_RST  = 8'd200;
  localparam logic [3:0] DEF_SPEED_RST   = 4'd4;

  // Remote command codes
  localparam logic [7:0] CMD_HALT     = 8'h36;
  localparam logic [7:0] CMD_SPEED_UP = 8'h29;
  localparam logic [7:0] CMD_SLOW     = 8'h37;
  localparam logic [7:0] CMD_AHEAD    = 8'h35;
  localparam logic [7:0] CMD_LEFT     = 8'h32;
  localparam logic [7:0] CMD_RIGHT    = 8'h34;
  localparam logic [7:0] CMD_BACKUP   = 8'h05;
  localparam logic [7:0] CMD_PIVOT    = 8'h09;
  localparam logic [7:0] CMD_SWAP     = 8'h01;

  // Item kinds
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_COMMAND = 1'b1;

  // Direction encodings (bit0 left reverse, bit1 right reverse)
  localparam logic [1:0] DIR_FWD  = 2'b00;
  localparam logic [1:0] DIR_REV  = 2'b11;
  localparam logic [1:0] DIR_SPIN = 2'b10;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DOWN = 2'd1,
    PH_UP   = 2'd2
  } ramp_phase_e;

  typedef enum logic [2:0] {
    ACT_NONE = 3'd0,
    ACT_STOP = 3'd1,
    ACT_FWD  = 3'd2,
    ACT_REV  = 3'd3,
    ACT_SPIN = 3'd4,
    ACT_SWAP = 3'd5
  } ramp_act_e;

  typedef struct packed {
    logic       op;
    logic [9:0] adc_sample;
    logic [7:0] command_code;
  } in_item_t;

  typedef struct packed {
    logic       left_enable;
    logic       right_enable;
    logic       left_reverse;
    logic       right_reverse;
    logic [3:0] left_duty_now;
    logic [3:0] right_duty_now;
    logic       obstacle_seen;
    logic       auto_mode;
    logic       busy_res;
  } out_item_t;

  // Complete drive state
  typedef struct packed {
    logic [3:0]  left_counter;
    logic [3:0]  right_counter;
    logic [3:0]  left_duty;
    logic [3:0]  right_duty;
    logic [1:0]  direction;
    logic        mode;
    logic        obstacle;
    logic        toggle;
    ramp_phase_e phase;
    ramp_act_e   pending;
    logic [7:0]  wait_cnt;
    logic        left_en;
    logic        right_en;
  } drive_st_t;

endpackage

>>> rtl/twpd_stream_if.sv
interface twpd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/two_wheel_pwm_drive_controller_unit.sv
// Two-wheel drive controller: software PWM for both wheels, obstacle flag
// with hysteresis, remote commands with speed ramps.
// Channels: in_i carries items (op 0 = PWM tick with ADC sample, op 1 =
// remote command); out_o carries one result per item with the enables,
// directions, duties, flags and ramp busy state after that item.
// The cfg_* port writes thresholds, ramp_ticks and the cruise speed; write
// only while no item is in flight.
// An accepted item is registered in the input register, then its result in the
// result register. Throughput: one item per cycle while out_o.ready is high,
// set by the single state-update stage between the input and result registers.
// Ramps run one duty step per ramp_ticks ticks as seen in the tick stream.
// Reset: duties, counters and enables zero, both wheels forward, manual
// mode, no obstacle, no ramp; configuration registers take their default values.
// Stall: the result register holds while out_o.ready is low; one more
// request is parked in the input register, after which in_i.ready drops.
module two_wheel_pwm_drive_controller_unit
  import twpd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  twpd_stream_if.sink           in_i,
  twpd_stream_if.source         out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration registers
  logic [9:0] present_thr_q;
  logic [9:0] clear_thr_q;
  logic [7:0] ramp_ticks_q;
  logic [3:0] def_speed_q;

  // Pipeline registers
  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_d, out_item_q;
  drive_st_t st_q, st_d;
  logic      advance;

  // ---- helpers ----
  function automatic logic [3:0] sat_inc(input logic [3:0] d);
    sat_inc = (d < PWM_STEPS) ? d + 4'd1 : d;
  endfunction

  function automatic logic [3:0] dec0(input logic [3:0] d);
    dec0 = (d != 4'd0) ? d - 4'd1 : d;
  endfunction

  function automatic logic [7:0] wait_load(input logic [7:0] rt);
    wait_load = (rt == 8'd0) ? 8'd0 : rt - 8'd1;
  endfunction

  function automatic drive_st_t ramp_end(input drive_st_t s);
    drive_st_t r;
    r          = s;
    r.phase    = PH_IDLE;
    r.pending  = ACT_NONE;
    r.wait_cnt = 8'd0;
    ramp_end   = r;
  endfunction

  // One ramp step: down to zero, then finish or start the up-ramp
  function automatic drive_st_t ramp_step(input drive_st_t s, input logic [7:0] rt,
                                          input logic [3:0] ds);
    drive_st_t r;
    logic      go_up;
    r     = s;
    go_up = 1'b0;
    case (s.phase)
      PH_DOWN: begin
        if (s.left_duty != 4'd0 || s.right_duty != 4'd0) begin
          r.left_duty  = dec0(s.left_duty);
          r.right_duty = dec0(s.right_duty);
          r.wait_cnt   = wait_load(rt);
        end else begin
          case (s.pending)
            ACT_FWD: begin
              r.direction = DIR_FWD;
              go_up       = 1'b1;
            end
            ACT_REV: begin
              r.direction = DIR_REV;
              go_up       = 1'b1;
            end
            ACT_SPIN: begin
              r.direction = DIR_SPIN;
              go_up       = 1'b1;
            end
            ACT_SWAP: begin
              r.mode = ~s.mode;
              r      = ramp_end(r);
            end
            default: r = ramp_end(r);
          endcase
          if (go_up) begin
            r.phase      = PH_UP;
            r.left_duty  = sat_inc(4'd0);
            r.right_duty = sat_inc(4'd0);
            r.wait_cnt   = wait_load(rt);
          end
        end
      end
      PH_UP: begin
        if (s.left_duty < ds && s.left_duty < PWM_STEPS) begin
          r.left_duty  = sat_inc(s.left_duty);
          r.right_duty = sat_inc(s.right_duty);
          r.wait_cnt   = wait_load(rt);
        end else begin
          r = ramp_end(r);
        end
      end
      default: r = ramp_end(r);
    endcase
    ramp_step = r;
  endfunction

  // PWM for one wheel: {counter, enable}
  function automatic logic [4:0] pwm_wheel(input logic [3:0] duty, input logic [3:0] cnt,
                                           input logic en);
    logic [3:0] c;
    logic       e;
    c = cnt;
    e = en;
    if (duty != 4'd0) begin
      if (c >= PWM_STEPS || c == 4'd0) begin
        c = 4'd0;
        e = 1'b1;
      end else if (c >= duty) begin
        e = 1'b0;
      end
      c = c + 4'd1;
    end else begin
      c = 4'd0;
      e = 1'b0;
    end
    pwm_wheel = {c, e};
  endfunction

  // ---- handshake ----
  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign out_o.valid = out_valid_q;
  assign out_o.payload = out_item_q;

  // ---- state update for the registered item ----
  always_comb begin
    logic      busy;
    drive_st_t s;
    busy = (st_q.phase == PH_DOWN) || (st_q.phase == PH_UP);
    s    = st_q;
    if (in_item_q.op == OP_TICK) begin
      {s.right_counter, s.right_en} = pwm_wheel(st_q.right_duty, st_q.right_counter,
                                                st_q.right_en);
      {s.left_counter, s.left_en}   = pwm_wheel(st_q.left_duty, st_q.left_counter,
                                                st_q.left_en);
      if (in_item_q.adc_sample > present_thr_q) begin
        s.obstacle = 1'b1;
      end else if (in_item_q.adc_sample < clear_thr_q) begin
        s.obstacle = 1'b0;
      end
      if (busy) begin
        if (st_q.wait_cnt != 8'd0) begin
          s.wait_cnt = st_q.wait_cnt - 8'd1;
        end else begin
          s = ramp_step(s, ramp_ticks_q, def_speed_q);
        end
      end else begin
        s.phase = PH_IDLE;
      end
    end else if (!busy) begin
      s.toggle = ~st_q.toggle;
      if (s.toggle) begin
        case (in_item_q.command_code)
          CMD_SPEED_UP: begin
            s.left_duty  = sat_inc(st_q.left_duty);
            s.right_duty = sat_inc(st_q.right_duty);
          end
          CMD_SLOW: begin
            s.left_duty  = dec0(st_q.left_duty);
            s.right_duty = dec0(st_q.right_duty);
          end
          CMD_LEFT:  s.left_duty  = dec0(st_q.left_duty);
          CMD_RIGHT: s.right_duty = dec0(st_q.right_duty);
          CMD_HALT, CMD_AHEAD, CMD_BACKUP, CMD_PIVOT, CMD_SWAP: begin
            s.phase = PH_DOWN;
            case (in_item_q.command_code)
              CMD_HALT:   s.pending = ACT_STOP;
              CMD_AHEAD:  s.pending = ACT_FWD;
              CMD_BACKUP: s.pending = ACT_REV;
              CMD_PIVOT:  s.pending = ACT_SPIN;
              default:    s.pending = ACT_SWAP;
            endcase
            s = ramp_step(s, ramp_ticks_q, def_speed_q);
          end
          default: ;
        endcase
      end
    end
    st_d = s;

    out_item_d.left_enable    = s.left_en;
    out_item_d.right_enable   = s.right_en;
    out_item_d.left_reverse   = s.direction[0];
    out_item_d.right_reverse  = s.direction[1];
    out_item_d.left_duty_now  = s.left_duty;
    out_item_d.right_duty_now = s.right_duty;
    out_item_d.obstacle_seen  = s.obstacle;
    out_item_d.auto_mode      = s.mode;
    out_item_d.busy_res       = (s.phase == PH_DOWN) || (s.phase == PH_UP);
  end

  // ---- configuration registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_thr_q <= PRESENT_THR_RST;
      clear_thr_q   <= CLEAR_THR_RST;
      ramp_ticks_q  <= RAMP_TICKS_RST;
      def_speed_q   <= DEF_SPEED_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PRESENT_THR: present_thr_q <= cfg_data_i;
        CFG_CLEAR_THR:   clear_thr_q   <= cfg_data_i;
        CFG_RAMP_TICKS:  ramp_ticks_q  <= cfg_data_i[7:0];
        CFG_DEF_SPEED:   def_speed_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // ---- control and state registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '{phase: PH_IDLE, pending: ACT_NONE, direction: DIR_FWD,
                       default: '0};
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_item_q <= in_i.payload;
    end
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

endmodule

>>> rtl/twpd_checker.sv
module twpd_checker
  import twpd_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_payload_i
);

  // Stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // Stalled result does not change
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_payload_i))
    else $error("result changed while stalled");

  // Duties never pass the PWM period
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_payload_i.left_duty_now <= PWM_STEPS) &&
                    (out_payload_i.right_duty_now <= PWM_STEPS))
    else $error("duty above PWM period");

  // A fresh result follows an accepted request through the input register
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !$past(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without a request");

endmodule

bind two_wheel_pwm_drive_controller_unit twpd_checker u_twpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload)
);
